/* src/env_sensor_compensation_unit_assert.svh */
// assertion macros shared by the checker of the compensation unit
`ifndef ENV_SENSOR_COMPENSATION_UNIT_ASSERT_SVH
`define ENV_SENSOR_COMPENSATION_UNIT_ASSERT_SVH

// same-edge implication, clocked on clk and held off during reset
`define ESC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("compensation unit check failed");

// implication after a fixed number of cycles
`define ESC_ASSERT_NEXT(lbl, ante, n, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
        else $error("compensation unit timing check failed");

`endif

/* src/esc_pkg.sv */
// types and constants of the environmental sensor compensation unit
package esc_pkg;

    localparam int PW = 64;                       // pressure arithmetic width
    localparam int MUL_LAT = 2;                   // wide multiplier latency
    localparam int DIV_LAT = PW + 2;              // divider latency
    localparam int DIV_IN_STAGE = 12;             // stage feeding the divider
    localparam int OUT_STAGE = DIV_IN_STAGE + DIV_LAT + 7;
    localparam int PIPE_LAT = OUT_STAGE + 1;      // accept edge to result edge

    localparam int CFG_AW = 3;
    localparam int CFG_DW = 64;

    localparam logic [CFG_AW-1:0] CFG_CAL_TEMP    = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_CAL_PRESS_A = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_CAL_PRESS_B = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_CAL_PRESS_C = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_CAL_HUM_A   = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_CAL_HUM_B   = 3'd5;

    localparam logic [16:0] HUM_MAX = 17'd102400;

    typedef struct packed {
        logic [19:0] adc_pressure;
        logic [19:0] adc_temperature;
        logic [15:0] adc_humidity;
    } esc_sample_t;

    typedef struct packed {
        logic signed [31:0] temperature_centi;
        logic [31:0]        pressure_q24_8;
        logic               pressure_invalid;
        logic [16:0]        humidity_q22_10;
    } esc_result_t;

endpackage

/* src/env_sensor_compensation_unit.sv */
// top level of the pressure, temperature and humidity compensation pipeline
//
// Fully pipelined compensator: one raw sample is taken on every clock cycle
// (busy never rises) and each result is marked by a one-cycle done strobe
// that cannot be held off. The latency is set by the pressure path: the wide
// products are built in pipelined multipliers and the signed 64-bit division
// runs one quotient bit per stage through a 66-stage divider. The user must
// write calibration words through the cfg port only while no sample is in
// flight; the block does not enforce it. Only the calibration registers and
// the valid line reset to zero, and no clearing pass is needed.
module env_sensor_compensation_unit
    import esc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  esc_sample_t       sample,
    output logic              done,
    output esc_result_t       result,
    input  logic              cfg_wr_en,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [CFG_DW-1:0] cfg_wdata
);

    localparam int TEMP_DLY = OUT_STAGE - 1 - 4;
    localparam int HUM_DLY  = OUT_STAGE - 1 - 15;

    // ------------------------------------------------------------------
    // calibration registers
    // ------------------------------------------------------------------
    logic [47:0] cal_temp_reg;
    logic [63:0] cal_press_a_reg, cal_press_b_reg;
    logic [15:0] cal_press_c_reg;
    logic [39:0] cal_hum_a_reg;
    logic [23:0] cal_hum_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_temp_reg    <= '0;
            cal_press_a_reg <= '0;
            cal_press_b_reg <= '0;
            cal_press_c_reg <= '0;
            cal_hum_a_reg   <= '0;
            cal_hum_b_reg   <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                CFG_CAL_TEMP:    cal_temp_reg    <= cfg_wdata[47:0];
                CFG_CAL_PRESS_A: cal_press_a_reg <= cfg_wdata;
                CFG_CAL_PRESS_B: cal_press_b_reg <= cfg_wdata;
                CFG_CAL_PRESS_C: cal_press_c_reg <= cfg_wdata[15:0];
                CFG_CAL_HUM_A:   cal_hum_a_reg   <= cfg_wdata[39:0];
                CFG_CAL_HUM_B:   cal_hum_b_reg   <= cfg_wdata[23:0];
                default:         ;
            endcase
        end
    end

    // unpacked coefficients, signed ones sign-extended to their formula width
    logic [31:0] t1, t2, t3, h1, h2, h3, h4, h5, h6;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;

    assign t1 = {16'b0, cal_temp_reg[15:0]};
    assign t2 = {{16{cal_temp_reg[31]}}, cal_temp_reg[31:16]};
    assign t3 = {{16{cal_temp_reg[47]}}, cal_temp_reg[47:32]};
    assign p1 = {48'b0, cal_press_a_reg[15:0]};
    assign p2 = {{48{cal_press_a_reg[31]}}, cal_press_a_reg[31:16]};
    assign p3 = {{48{cal_press_a_reg[47]}}, cal_press_a_reg[47:32]};
    assign p4 = {{48{cal_press_a_reg[63]}}, cal_press_a_reg[63:48]};
    assign p5 = {{48{cal_press_b_reg[15]}}, cal_press_b_reg[15:0]};
    assign p6 = {{48{cal_press_b_reg[31]}}, cal_press_b_reg[31:16]};
    assign p7 = {{48{cal_press_b_reg[47]}}, cal_press_b_reg[47:32]};
    assign p8 = {{48{cal_press_b_reg[63]}}, cal_press_b_reg[63:48]};
    assign p9 = {{48{cal_press_c_reg[15]}}, cal_press_c_reg[15:0]};
    assign h1 = {24'b0, cal_hum_a_reg[7:0]};
    assign h2 = {{16{cal_hum_a_reg[23]}}, cal_hum_a_reg[23:8]};
    assign h3 = {24'b0, cal_hum_a_reg[31:24]};
    assign h6 = {{24{cal_hum_a_reg[39]}}, cal_hum_a_reg[39:32]};
    assign h4 = {{20{cal_hum_b_reg[11]}}, cal_hum_b_reg[11:0]};
    assign h5 = {{20{cal_hum_b_reg[23]}}, cal_hum_b_reg[23:12]};

    // ------------------------------------------------------------------
    // item valid line: one bit per stage, shifts every cycle
    // ------------------------------------------------------------------
    logic                 accept;
    logic [OUT_STAGE:0]   vld_reg;

    assign busy   = 1'b0;   // never stalls
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[OUT_STAGE-1:0], accept};
    end

    // ------------------------------------------------------------------
    // stage 0: sample capture
    // ------------------------------------------------------------------
    logic [19:0] s0_adc_p_reg, s0_adc_t_reg;
    logic [15:0] s0_adc_h_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s0_adc_p_reg <= sample.adc_pressure;
            s0_adc_t_reg <= sample.adc_temperature;
            s0_adc_h_reg <= sample.adc_humidity;
        end
    end

    // ------------------------------------------------------------------
    // temperature, stages 1 to 4 (32-bit wrapping arithmetic)
    // ------------------------------------------------------------------
    logic [31:0] d1, d2;
    logic [31:0] s1_d1t2_next, s1_d1t2_reg, s1_dd_next, s1_dd_reg;
    logic [31:0] s2_v1_next, s2_v1_reg, s2_q3_next, s2_q3_reg, sq_shr;
    logic [31:0] s3_tfine_next, s3_tfine_reg, q3_shr;
    logic [31:0] tf5;
    logic [31:0] s4_temp_next, s4_temp_reg, s4_hx_next, s4_hx_reg;
    logic [63:0] s4_w1_next, s4_w1_reg;

    always_comb
    begin
        d1 = {15'b0, s0_adc_t_reg[19:3]} - {15'b0, t1[15:0], 1'b0};
        d2 = {16'b0, s0_adc_t_reg[19:4]} - t1;
        s1_d1t2_next = d1 * t2;
        s1_dd_next   = d2 * d2;

        s2_v1_next = $unsigned($signed(s1_d1t2_reg) >>> 11);
        sq_shr     = $unsigned($signed(s1_dd_reg) >>> 12);
        s2_q3_next = sq_shr * t3;

        q3_shr        = $unsigned($signed(s2_q3_reg) >>> 14);
        s3_tfine_next = s2_v1_reg + q3_shr;

        // fine temperature fans out to all three formulas here
        tf5          = s3_tfine_reg + (s3_tfine_reg << 2) + 32'd128;
        s4_temp_next = $unsigned($signed(tf5) >>> 8);
        s4_w1_next   = {{32{s3_tfine_reg[31]}}, s3_tfine_reg} - 64'd128000;
        s4_hx_next   = s3_tfine_reg - 32'd76800;
    end

    always_ff @(posedge clk)
    begin
        s1_d1t2_reg  <= s1_d1t2_next;
        s1_dd_reg    <= s1_dd_next;
        s2_v1_reg    <= s2_v1_next;
        s2_q3_reg    <= s2_q3_next;
        s3_tfine_reg <= s3_tfine_next;
        s4_temp_reg  <= s4_temp_next;
        s4_w1_reg    <= s4_w1_next;
        s4_hx_reg    <= s4_hx_next;
    end

    // ------------------------------------------------------------------
    // pressure, 64-bit wrapping arithmetic
    // ------------------------------------------------------------------
    logic [63:0] sq_s6, w1p5_s6, w1p2_s6, sqp6_s8, sqp3_s8;

    // stages 5 and 6: w1 squared and the linear terms
    esc_mul64 u_mul_sq (.clk(clk), .a(s4_w1_reg), .b(s4_w1_reg), .p(sq_s6));
    esc_mul64 u_mul_p5 (.clk(clk), .a(s4_w1_reg), .b(p5),        .p(w1p5_s6));
    esc_mul64 u_mul_p2 (.clk(clk), .a(s4_w1_reg), .b(p2),        .p(w1p2_s6));
    // stages 7 and 8: square terms
    esc_mul64 u_mul_p6 (.clk(clk), .a(sq_s6),     .b(p6),        .p(sqp6_s8));
    esc_mul64 u_mul_p3 (.clk(clk), .a(sq_s6),     .b(p3),        .p(sqp3_s8));

    logic [63:0] w1p5_dly_reg [MUL_LAT];
    logic [63:0] w1p2_dly_reg [MUL_LAT];
    logic [19:0] adc_p_dly_reg [9];

    logic [63:0] s9_w2_next, s9_w2_reg, s9_w1b_next, s9_w1b_reg, sqp3_shr;
    logic [63:0] p0;
    logic [63:0] s10_t47_next, s10_t47_reg, s10_num_next, s10_num_reg;

    always_comb
    begin
        sqp3_shr    = $unsigned($signed(sqp3_s8) >>> 8);
        s9_w2_next  = sqp6_s8 + (w1p5_dly_reg[MUL_LAT-1] << 17) + (p4 << 35);
        s9_w1b_next = sqp3_shr + (w1p2_dly_reg[MUL_LAT-1] << 12);

        p0           = 64'd1048576 - {44'b0, adc_p_dly_reg[8]};
        s10_t47_next = 64'h0000_8000_0000_0000 + s9_w1b_reg;
        s10_num_next = (p0 << 31) - s9_w2_reg;
    end

    always_ff @(posedge clk)
    begin
        w1p5_dly_reg[0]  <= w1p5_s6;
        w1p2_dly_reg[0]  <= w1p2_s6;
        for (int i = 1; i < MUL_LAT; i++)
        begin
            w1p5_dly_reg[i] <= w1p5_dly_reg[i-1];
            w1p2_dly_reg[i] <= w1p2_dly_reg[i-1];
        end
        adc_p_dly_reg[0] <= s0_adc_p_reg;
        for (int i = 1; i < 9; i++)
            adc_p_dly_reg[i] <= adc_p_dly_reg[i-1];
        s9_w2_reg    <= s9_w2_next;
        s9_w1b_reg   <= s9_w1b_next;
        s10_t47_reg  <= s10_t47_next;
        s10_num_reg  <= s10_num_next;
    end

    // stages 11 and 12: divisor and scaled dividend
    logic [63:0] w1c_raw_s12, num_s12, div_den;
    logic [63:0] q_s78;
    logic        dz_s78;

    esc_mul64 u_mul_p1    (.clk(clk), .a(s10_t47_reg), .b(p1),       .p(w1c_raw_s12));
    esc_mul64 u_mul_scale (.clk(clk), .a(s10_num_reg), .b(64'd3125), .p(num_s12));

    assign div_den = $unsigned($signed(w1c_raw_s12) >>> 33);

    // stages 13 to 78: signed division, zero divisor flagged alongside
    esc_div64 u_div (.clk(clk), .n(num_s12), .d(div_den), .q(q_s78), .dz(dz_s78));

    // stages 79 to 82: second-order correction terms
    logic [63:0] q13, qq_s80, p8q_s80, p9qq_s82;

    assign q13 = $unsigned($signed(q_s78) >>> 13);

    esc_mul64 u_mul_qq (.clk(clk), .a(q13), .b(q13),   .p(qq_s80));
    esc_mul64 u_mul_p8 (.clk(clk), .a(p8),  .b(q_s78), .p(p8q_s80));
    esc_mul64 u_mul_p9 (.clk(clk), .a(p9),  .b(qq_s80), .p(p9qq_s82));

    logic [63:0] q_dly_reg   [2*MUL_LAT];
    logic [63:0] p8q_dly_reg [MUL_LAT];
    logic        dz_dly_reg  [6];

    logic [63:0] r1, r2, s83_sum_next, s83_sum_reg, sum_shr;
    logic [63:0] s84_pp_next, s84_pp_reg;
    logic [31:0] press;

    always_comb
    begin
        r1           = $unsigned($signed(p9qq_s82) >>> 25);
        r2           = $unsigned($signed(p8q_dly_reg[MUL_LAT-1]) >>> 19);
        s83_sum_next = q_dly_reg[2*MUL_LAT-1] + r1 + r2;

        sum_shr     = $unsigned($signed(s83_sum_reg) >>> 8);
        s84_pp_next = sum_shr + (p7 << 4);

        // zero divisor, then clamp to the unsigned 32-bit range
        priority if (dz_dly_reg[5])
            press = 32'd0;
        else if (s84_pp_reg[63])
            press = 32'd0;
        else if (s84_pp_reg[62:32] != '0)
            press = 32'hFFFF_FFFF;
        else
            press = s84_pp_reg[31:0];
    end

    always_ff @(posedge clk)
    begin
        q_dly_reg[0] <= q_s78;
        for (int i = 1; i < 2*MUL_LAT; i++)
            q_dly_reg[i] <= q_dly_reg[i-1];
        p8q_dly_reg[0] <= p8q_s80;
        for (int i = 1; i < MUL_LAT; i++)
            p8q_dly_reg[i] <= p8q_dly_reg[i-1];
        dz_dly_reg[0] <= dz_s78;
        for (int i = 1; i < 6; i++)
            dz_dly_reg[i] <= dz_dly_reg[i-1];
        s83_sum_reg <= s83_sum_next;
        s84_pp_reg  <= s84_pp_next;
    end

    // ------------------------------------------------------------------
    // humidity, stages 5 to 15 (32-bit wrapping arithmetic)
    // ------------------------------------------------------------------
    logic [15:0] adc_h_dly_reg [5];
    logic [31:0] a_dly_reg [4];
    logic [31:0] x2_dly_reg [2];

    logic [31:0] s5_m5_next, s5_m5_reg, s5_m6_next, s5_m6_reg, s5_m3_next, s5_m3_reg;
    logic [31:0] a_sum, s6_a_next, s6_a_reg, s6_u_next, s6_u_reg, s6_v_next, s6_v_reg;
    logic [31:0] s7_mm_next, s7_mm_reg, s8_k_next, s8_k_reg;
    logic [31:0] s9_kk_next, s9_kk_reg, kk_sum, s10_b_next, s10_b_reg;
    logic [31:0] s11_x2_next, s11_x2_reg, x2_shr, s12_ss_next, s12_ss_reg;
    logic [31:0] ss_shr, s13_y_next, s13_y_reg, y_shr, s14_x3_next, s14_x3_reg;
    logic [16:0] s15_hum_next, s15_hum_reg;

    always_comb
    begin
        s5_m5_next = h5 * s4_hx_reg;
        s5_m6_next = s4_hx_reg * h6;
        s5_m3_next = s4_hx_reg * h3;

        a_sum      = ({16'b0, adc_h_dly_reg[4]} << 14) - (h4 << 20) - s5_m5_reg
                     + 32'd16384;
        s6_a_next  = $unsigned($signed(a_sum) >>> 15);
        s6_u_next  = $unsigned($signed(s5_m6_reg) >>> 10);
        s6_v_next  = $unsigned($signed(s5_m3_reg) >>> 11) + 32'd32768;

        s7_mm_next = s6_u_reg * s6_v_reg;
        s8_k_next  = $unsigned($signed(s7_mm_reg) >>> 10) + 32'd2097152;
        s9_kk_next = s8_k_reg * h2;
        kk_sum     = s9_kk_reg + 32'd8192;
        s10_b_next = $unsigned($signed(kk_sum) >>> 14);

        s11_x2_next = a_dly_reg[3] * s10_b_reg;
        x2_shr      = $unsigned($signed(s11_x2_reg) >>> 15);
        s12_ss_next = x2_shr * x2_shr;
        ss_shr      = $unsigned($signed(s12_ss_reg) >>> 7);
        s13_y_next  = ss_shr * h1;
        y_shr       = $unsigned($signed(s13_y_reg) >>> 4);
        s14_x3_next = x2_dly_reg[1] - y_shr;

        // clamp to 0..100 percent before dropping the low 12 bits
        priority if (s14_x3_reg[31])
            s15_hum_next = '0;
        else if (s14_x3_reg > 32'd419430400)
            s15_hum_next = HUM_MAX;
        else
            s15_hum_next = s14_x3_reg[28:12];
    end

    always_ff @(posedge clk)
    begin
        adc_h_dly_reg[0] <= s0_adc_h_reg;
        for (int i = 1; i < 5; i++)
            adc_h_dly_reg[i] <= adc_h_dly_reg[i-1];
        a_dly_reg[0] <= s6_a_reg;
        for (int i = 1; i < 4; i++)
            a_dly_reg[i] <= a_dly_reg[i-1];
        x2_dly_reg[0] <= s11_x2_reg;
        x2_dly_reg[1] <= x2_dly_reg[0];
        s5_m5_reg   <= s5_m5_next;
        s5_m6_reg   <= s5_m6_next;
        s5_m3_reg   <= s5_m3_next;
        s6_a_reg    <= s6_a_next;
        s6_u_reg    <= s6_u_next;
        s6_v_reg    <= s6_v_next;
        s7_mm_reg   <= s7_mm_next;
        s8_k_reg    <= s8_k_next;
        s9_kk_reg   <= s9_kk_next;
        s10_b_reg   <= s10_b_next;
        s11_x2_reg  <= s11_x2_next;
        s12_ss_reg  <= s12_ss_next;
        s13_y_reg   <= s13_y_next;
        s14_x3_reg  <= s14_x3_next;
        s15_hum_reg <= s15_hum_next;
    end

    // ------------------------------------------------------------------
    // alignment of temperature and humidity with the pressure result
    // ------------------------------------------------------------------
    logic [31:0] temp_dly_reg [TEMP_DLY];
    logic [16:0] hum_dly_reg  [HUM_DLY];
    esc_result_t result_reg;

    always_ff @(posedge clk)
    begin
        temp_dly_reg[0] <= s4_temp_reg;
        for (int i = 1; i < TEMP_DLY; i++)
            temp_dly_reg[i] <= temp_dly_reg[i-1];
        hum_dly_reg[0] <= s15_hum_reg;
        for (int i = 1; i < HUM_DLY; i++)
            hum_dly_reg[i] <= hum_dly_reg[i-1];

        // output register, last stage
        result_reg.temperature_centi <= $signed(temp_dly_reg[TEMP_DLY-1]);
        result_reg.pressure_q24_8    <= press;
        result_reg.pressure_invalid  <= dz_dly_reg[5];
        result_reg.humidity_q22_10   <= hum_dly_reg[HUM_DLY-1];
    end

    assign done   = vld_reg[OUT_STAGE];
    assign result = result_reg;

endmodule

/* src/esc_mul64.sv */
// pipelined low-half 64 by 64 multiplier built from 32 by 32 products
module esc_mul64
    import esc_pkg::*;
(
    input  logic          clk,
    input  logic [PW-1:0] a,
    input  logic [PW-1:0] b,
    output logic [PW-1:0] p
);

    logic [PW-1:0]   ll_next, ll_reg;
    logic [PW/2-1:0] lh_next, lh_reg, hl_next, hl_reg;
    logic [PW-1:0]   p_reg;

    assign ll_next = PW'(a[PW/2-1:0]) * PW'(b[PW/2-1:0]);
    assign lh_next = a[PW/2-1:0] * b[PW-1:PW/2];
    assign hl_next = a[PW-1:PW/2] * b[PW/2-1:0];

    always_ff @(posedge clk)
    begin
        ll_reg <= ll_next;
        lh_reg <= lh_next;
        hl_reg <= hl_next;
        p_reg  <= ll_reg + {lh_reg + hl_reg, {(PW/2){1'b0}}};
    end

    assign p = p_reg;

endmodule

/* src/esc_div64.sv */
// pipelined signed divider, one quotient bit per stage, truncating toward zero
module esc_div64
    import esc_pkg::*;
(
    input  logic          clk,
    input  logic [PW-1:0] n,
    input  logic [PW-1:0] d,
    output logic [PW-1:0] q,
    output logic          dz
);

    logic [PW-1:0] rem_reg [PW+1];
    logic [PW-1:0] nq_reg  [PW+1];
    logic [PW-1:0] md_reg  [PW+1];
    logic          neg_reg [PW+1];
    logic          dz_reg  [PW+1];

    logic [PW:0]   trial   [PW];
    logic [PW:0]   diff    [PW];
    logic [PW-1:0] rem_next [PW];
    logic [PW-1:0] nq_next  [PW];

    logic [PW-1:0] q_reg;
    logic          dz_out_reg;

    always_comb
    begin
        for (int i = 0; i < PW; i++)
        begin
            trial[i]    = {rem_reg[i], nq_reg[i][PW-1]};
            diff[i]     = trial[i] - {1'b0, md_reg[i]};
            rem_next[i] = diff[i][PW] ? trial[i][PW-1:0] : diff[i][PW-1:0];
            nq_next[i]  = {nq_reg[i][PW-2:0], ~diff[i][PW]};
        end
    end

    always_ff @(posedge clk)
    begin
        // magnitudes and sign
        rem_reg[0] <= '0;
        nq_reg[0]  <= n[PW-1] ? (~n + 1'b1) : n;
        md_reg[0]  <= d[PW-1] ? (~d + 1'b1) : d;
        neg_reg[0] <= n[PW-1] ^ d[PW-1];
        dz_reg[0]  <= (d == '0);
        for (int i = 0; i < PW; i++)
        begin
            rem_reg[i+1] <= rem_next[i];
            nq_reg[i+1]  <= nq_next[i];
            md_reg[i+1]  <= md_reg[i];
            neg_reg[i+1] <= neg_reg[i];
            dz_reg[i+1]  <= dz_reg[i];
        end
        q_reg      <= neg_reg[PW] ? (~nq_reg[PW] + 1'b1) : nq_reg[PW];
        dz_out_reg <= dz_reg[PW];
    end

    assign q  = q_reg;
    assign dz = dz_out_reg;

endmodule

/* src/esc_checker.sv */
// port-level checks of the compensation unit and their binding
`include "env_sensor_compensation_unit_assert.svh"

module esc_checker
    import esc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input esc_result_t result
);

    // every result comes from an item taken a fixed latency earlier
    `ESC_ASSERT_IMP(a_done_has_item, done, $past(start && !busy && rst_n, PIPE_LAT))
    // and every item taken gives its result after that latency
    `ESC_ASSERT_NEXT(a_item_gives_done, start && !busy, PIPE_LAT, done)
    // a zero divisor reports zero pressure
    `ESC_ASSERT_IMP(a_invalid_zero, done && result.pressure_invalid, result.pressure_q24_8 == 32'd0)
    // humidity never leaves the clamp range
    `ESC_ASSERT_IMP(a_hum_range, done, result.humidity_q22_10 <= HUM_MAX)

endmodule

bind env_sensor_compensation_unit esc_checker u_esc_checker
(
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
